### hdl/bdeq_pkg.sv
`timescale 1ns / 1ps
// Shared constants, operation and status codes, types and helper functions
// for the bounded double-ended queue. No dependencies.
package bdeq_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int SUM_W      = CNT_W + 1;
    localparam int CAP_W      = 7;
    localparam int LIM_W      = (CAP_W > CNT_W) ? CAP_W : CNT_W;
    localparam int OP_W       = 3;
    localparam int STATUS_W   = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
    localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd4;
    localparam logic [OP_W-1:0] OP_PEEK_REAR  = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [ADDR_W-1:0] addr;
    } ptr_info_t;

    // Adds an offset of at most DEPTH to a store index and wraps it once.
    function automatic logic [ADDR_W-1:0] wrap_sum(input logic [ADDR_W-1:0] base,
                                                   input logic [CNT_W-1:0]  off);
        logic [SUM_W-1:0] s;
        s = SUM_W'(base) + SUM_W'(off);
        if (s >= SUM_W'(DEPTH))
        begin
            s = s - SUM_W'(DEPTH);
        end
        return s[ADDR_W-1:0];
    endfunction

    // A capacity of zero acts as one, and one above DEPTH acts as DEPTH.
    function automatic logic [CNT_W-1:0] fill_limit(input logic [CAP_W-1:0] cap);
        logic [LIM_W-1:0] c;
        c = LIM_W'(cap);
        if (c == '0)
        begin
            c = LIM_W'(1);
        end
        if (c > LIM_W'(DEPTH))
        begin
            c = LIM_W'(DEPTH);
        end
        return c[CNT_W-1:0];
    endfunction

endpackage

### hdl/bdeq_ram.sv
`timescale 1ns / 1ps
// Generic single-port synchronous RAM with a registered read port.
// No dependencies.
module bdeq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/bdeq_ptr.sv
`timescale 1ns / 1ps
// Head index and fill count of the circular store, with full and empty
// detection and the store address for each operation. Uses bdeq_pkg.
module bdeq_ptr (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [bdeq_pkg::CAP_W-1:0]    cap,
    input  logic [bdeq_pkg::OP_W-1:0]     op,
    input  logic                          fire,
    output bdeq_pkg::ptr_info_t           info
);

    logic [bdeq_pkg::ADDR_W-1:0] head_reg;
    logic [bdeq_pkg::ADDR_W-1:0] head_next;
    logic [bdeq_pkg::CNT_W-1:0]  fill_reg;
    logic [bdeq_pkg::CNT_W-1:0]  fill_next;
    logic [bdeq_pkg::ADDR_W-1:0] head_dec;
    logic [bdeq_pkg::ADDR_W-1:0] head_inc;
    logic                        full;
    logic                        empty;

    assign full  = fill_reg >= bdeq_pkg::fill_limit(cap);
    assign empty = fill_reg == '0;

    assign head_dec = (head_reg == '0) ? bdeq_pkg::ADDR_W'(bdeq_pkg::DEPTH - 1)
                                       : head_reg - bdeq_pkg::ADDR_W'(1);
    assign head_inc = bdeq_pkg::wrap_sum(head_reg, bdeq_pkg::CNT_W'(1));

    always_comb
    begin
        info.full  = full;
        info.empty = empty;
        unique case (op)
            bdeq_pkg::OP_PUSH_FRONT: info.addr = head_dec;
            bdeq_pkg::OP_PUSH_REAR:  info.addr = bdeq_pkg::wrap_sum(head_reg, fill_reg);
            bdeq_pkg::OP_POP_REAR,
            bdeq_pkg::OP_PEEK_REAR:
                info.addr = bdeq_pkg::wrap_sum(head_reg, fill_reg - bdeq_pkg::CNT_W'(1));
            default:                 info.addr = head_reg;
        endcase
    end

    always_comb
    begin
        head_next = head_reg;
        fill_next = fill_reg;
        if (fire)
        begin
            unique case (op)
                bdeq_pkg::OP_PUSH_FRONT:
                begin
                    if (!full)
                    begin
                        head_next = head_dec;
                        fill_next = fill_reg + bdeq_pkg::CNT_W'(1);
                    end
                end
                bdeq_pkg::OP_PUSH_REAR:
                begin
                    if (!full)
                    begin
                        fill_next = fill_reg + bdeq_pkg::CNT_W'(1);
                    end
                end
                bdeq_pkg::OP_POP_FRONT:
                begin
                    if (!empty)
                    begin
                        head_next = head_inc;
                        fill_next = fill_reg - bdeq_pkg::CNT_W'(1);
                    end
                end
                bdeq_pkg::OP_POP_REAR:
                begin
                    if (!empty)
                    begin
                        fill_next = fill_reg - bdeq_pkg::CNT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

endmodule

### hdl/bounded_double_ended_queue_core.sv
`timescale 1ns / 1ps
// Top level of the bounded double-ended queue: handshakes, capacity register,
// entry RAM and result register. Uses bdeq_pkg, bdeq_ptr and bdeq_ram.
//
//   Channel  Signals                          Beat
//   input    in_valid/in_ready, operation,    one operation
//            value
//   output   out_valid/out_ready, data,       one result
//            status
//   config   cfg_we, cfg_wdata                capacity write, no wait
//
// A push, an operation on an empty queue and an unused code go straight to the
// result register; a pop or peek waits in a read state for the registered RAM read.
// The result register lets a new beat in while the previous result is taken.
// A stalled output holds the input off until the result is taken.
// Reset empties the queue and sets the capacity to 64; the RAM needs no clearing.
module bounded_double_ended_queue_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [bdeq_pkg::OP_W-1:0]          operation,
    input  logic signed [bdeq_pkg::DATA_WIDTH-1:0] value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [bdeq_pkg::DATA_WIDTH-1:0] data,
    output logic [bdeq_pkg::STATUS_W-1:0]      status,
    input  logic                               cfg_we,
    input  logic [bdeq_pkg::CAP_W-1:0]         cfg_wdata
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic                               state_reg;
    logic                               state_next;
    logic [bdeq_pkg::CAP_W-1:0]         cap_reg;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic [bdeq_pkg::DATA_WIDTH-1:0]    data_reg;
    logic [bdeq_pkg::DATA_WIDTH-1:0]    data_next;
    logic [bdeq_pkg::STATUS_W-1:0]      status_reg;
    logic [bdeq_pkg::STATUS_W-1:0]      status_next;
    logic                               fire;
    logic                               is_push;
    logic                               is_read;
    logic                               mem_we;
    logic                               mem_re;
    logic [bdeq_pkg::DATA_WIDTH-1:0]    mem_rdata;
    bdeq_pkg::ptr_info_t                info;

    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign fire     = in_valid && in_ready;

    assign is_push = (operation == bdeq_pkg::OP_PUSH_FRONT) ||
                     (operation == bdeq_pkg::OP_PUSH_REAR);
    assign is_read = (operation == bdeq_pkg::OP_POP_FRONT) ||
                     (operation == bdeq_pkg::OP_POP_REAR) ||
                     (operation == bdeq_pkg::OP_PEEK_FRONT) ||
                     (operation == bdeq_pkg::OP_PEEK_REAR);

    assign mem_we = fire && is_push && !info.full;
    assign mem_re = fire && is_read && !info.empty;

    bdeq_ptr u_ptr (
        .clk   (clk),
        .rst_n (rst_n),
        .cap   (cap_reg),
        .op    (operation),
        .fire  (fire),
        .info  (info)
    );

    bdeq_ram #(
        .WIDTH (bdeq_pkg::DATA_WIDTH),
        .DEPTH (bdeq_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (info.addr),
        .wdata (value),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        data_next      = data_reg;
        status_next    = status_reg;
        priority if (state_reg == ST_READ)
        begin
            state_next     = ST_IDLE;
            out_valid_next = 1'b1;
            data_next      = mem_rdata;
            status_next    = bdeq_pkg::STATUS_OK;
        end
        else if (mem_re)
        begin
            state_next     = ST_READ;
            out_valid_next = 1'b0;
        end
        else if (fire)
        begin
            out_valid_next = 1'b1;
            data_next      = '0;
            if (is_push && info.full)
            begin
                status_next = bdeq_pkg::STATUS_FULL;
            end
            else if (is_read)
            begin
                status_next = bdeq_pkg::STATUS_EMPTY;
            end
            else
            begin
                status_next = bdeq_pkg::STATUS_OK;
            end
        end
        else
        begin
            if (out_ready)
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cap_reg       <= bdeq_pkg::CAP_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg   <= data_next;
        status_reg <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign data      = data_reg;
    assign status    = status_reg;

endmodule
